// ===== hdl/aids_pkg.sv =====
package aids_pkg;

  // default number of stored entries
  localparam int unsigned DEPTH_DEF = 64;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT_POS = 3'd1,
    OP_INSERT_MID = 3'd2,
    OP_DELETE     = 3'd3,
    OP_SORT       = 3'd4,
    OP_DUMP       = 3'd5
  } op_e;

  // status codes of a result item
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD_POS = 3'd2,
    ST_SHORT   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // input item
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [5:0]         element_index;
    logic [6:0]         entry_count;
    logic               last;
  } res_item_t;

endpackage

// ===== hdl/array_insert_delete_sort_engine_core.sv =====
// channel   | ports                      | handshake
// ----------+----------------------------+-------------------------------------
// command   | start_i, busy_o, item_i    | item taken when start_i && !busy_o
// result    | res_valid_o, res_o         | one cycle per result, cannot stall
//
// Append, error answers, insert at the end, short delete and short sort finish
// straight from idle; other inserts, delete, dump and sort step through the
// memory states with at most one memory read and one memory write per cycle.
// Reset clears the state, the entry count and the result valid flag; the
// contents memory needs no clearing. Results are registered and appear in the
// cycle after they are formed; the last result of an item comes with busy_o
// low, so the next item may be taken in that cycle.
module array_insert_delete_sort_engine_core #(
  parameter int unsigned DEPTH = aids_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  aids_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output aids_pkg::res_item_t res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_MOVE    = 7'b0000010,
    S_PUT     = 7'b0000100,
    S_SRT_LI  = 7'b0001000,
    S_SRT_CMP = 7'b0010000,
    S_SRT_WI  = 7'b0100000,
    S_DMP     = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       ra_q, ra_d;
  logic [AW-1:0]       wa_q, wa_d;
  logic [AW-1:0]       end_q, end_d;
  logic                up_q, up_d;
  logic [AW-1:0]       put_q, put_d;
  logic [31:0]         val_q, val_d;
  logic [AW-1:0]       i_q, i_d;
  logic [31:0]         cur_q, cur_d;
  aids_pkg::res_item_t res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [31:0]         mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [31:0]         mem_rdata;

  logic                full;
  logic [AW-1:0]       ins_idx;
  logic [PW-1:0]       pos_x;
  logic [PW-1:0]       lim_x;
  logic [AW-1:0]       nxt_ra;
  logic                dmp_last;

  // single-entry result of an operation
  function automatic aids_pkg::res_item_t make_res(aids_pkg::status_e st,
                                                   logic [CW-1:0] n);
    aids_pkg::res_item_t r;
    r.status        = st;
    r.element       = '0;
    r.element_index = '0;
    r.entry_count   = 7'(n);
    r.last          = 1'b1;
    return r;
  endfunction

  aids_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // decode helpers
  assign full     = (count_q == CW'(DEPTH));
  assign pos_x    = PW'(item_i.position);
  assign lim_x    = PW'(count_q) + PW'(1);
  assign ins_idx  = (item_i.op == aids_pkg::OP_INSERT_POS) ?
                    AW'(item_i.position - 7'd1) : AW'(count_q >> 1);
  assign nxt_ra   = up_q ? (ra_q + AW'(1)) : (ra_q - AW'(1));
  assign dmp_last = ((CW'(ra_q) + CW'(1)) == count_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ra_d        = ra_q;
    wa_d        = wa_q;
    end_d       = end_q;
    up_d        = up_q;
    put_d       = put_q;
    val_d       = val_q;
    i_d         = i_q;
    cur_d       = cur_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (item_i.op)
            aids_pkg::OP_APPEND: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d = make_res(aids_pkg::ST_FULL, count_q);
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_q);
                mem_wdata = item_i.value;
                count_d   = count_q + CW'(1);
                res_d     = make_res(aids_pkg::ST_OK, count_q + CW'(1));
              end
            end
            aids_pkg::OP_INSERT_POS, aids_pkg::OP_INSERT_MID: begin
              if (full) begin
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_FULL, count_q);
              end else if ((item_i.op == aids_pkg::OP_INSERT_POS) &&
                           ((pos_x == '0) || (pos_x > lim_x))) begin
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_BAD_POS, count_q);
              end else if (CW'(ins_idx) == count_q) begin
                // insert at the end: no shift
                mem_we      = 1'b1;
                mem_waddr   = ins_idx;
                mem_wdata   = item_i.value;
                count_d     = count_q + CW'(1);
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_OK, count_q + CW'(1));
              end else begin
                // shift right from the top entry down to the insert index
                mem_re    = 1'b1;
                mem_raddr = AW'(count_q - CW'(1));
                ra_d      = AW'(count_q - CW'(1));
                wa_d      = AW'(count_q);
                end_d     = ins_idx;
                up_d      = 1'b0;
                put_d     = ins_idx;
                val_d     = item_i.value;
                state_d   = S_MOVE;
              end
            end
            aids_pkg::OP_DELETE: begin
              if (count_q < CW'(3)) begin
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_SHORT, count_q);
              end else if (count_q == CW'(3)) begin
                count_d     = count_q - CW'(1);
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_OK, count_q - CW'(1));
              end else begin
                // shift left over index 2
                mem_re    = 1'b1;
                mem_raddr = AW'(3);
                ra_d      = AW'(3);
                wa_d      = AW'(2);
                end_d     = AW'(count_q - CW'(1));
                up_d      = 1'b1;
                state_d   = S_MOVE;
              end
            end
            aids_pkg::OP_SORT: begin
              if (count_q < CW'(2)) begin
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_OK, count_q);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                i_d       = '0;
                state_d   = S_SRT_LI;
              end
            end
            aids_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = make_res(aids_pkg::ST_EMPTY, count_q);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ra_d      = '0;
                state_d   = S_DMP;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = make_res(aids_pkg::ST_OK, count_q);
            end
          endcase
        end
      end

      // one entry moved per cycle, next read overlaps the write
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = wa_q;
        mem_wdata = mem_rdata;
        if (ra_q != end_q) begin
          mem_re    = 1'b1;
          mem_raddr = nxt_ra;
          ra_d      = nxt_ra;
          wa_d      = up_q ? (wa_q + AW'(1)) : (wa_q - AW'(1));
        end else if (up_q) begin
          count_d     = count_q - CW'(1);
          res_valid_d = 1'b1;
          res_d       = make_res(aids_pkg::ST_OK, count_q - CW'(1));
          state_d     = S_IDLE;
        end else begin
          state_d = S_PUT;
        end
      end

      // place the inserted value into the opened slot
      S_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = put_q;
        mem_wdata   = val_q;
        count_d     = count_q + CW'(1);
        res_valid_d = 1'b1;
        res_d       = make_res(aids_pkg::ST_OK, count_q + CW'(1));
        state_d     = S_IDLE;
      end

      // load entry i as the running maximum, start reading j = i + 1
      S_SRT_LI: begin
        cur_d     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = i_q + AW'(1);
        ra_d      = i_q + AW'(1);
        state_d   = S_SRT_CMP;
      end

      // compare entry j against the held entry i, swap when larger
      S_SRT_CMP: begin
        if ($signed(mem_rdata) > $signed(cur_q)) begin
          mem_we    = 1'b1;
          mem_waddr = ra_q;
          mem_wdata = cur_q;
          cur_d     = mem_rdata;
        end
        if ((CW'(ra_q) + CW'(1)) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ra_q + AW'(1);
          ra_d      = ra_q + AW'(1);
        end else begin
          state_d = S_SRT_WI;
        end
      end

      // write back entry i, then read the next i or finish the sort
      S_SRT_WI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = cur_q;
        if ((CW'(i_q) + CW'(2)) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q + AW'(1);
          i_d       = i_q + AW'(1);
          state_d   = S_SRT_LI;
        end else begin
          res_valid_d = 1'b1;
          res_d       = make_res(aids_pkg::ST_OK, count_q);
          state_d     = S_IDLE;
        end
      end

      // stream one stored entry per cycle
      S_DMP: begin
        res_valid_d         = 1'b1;
        res_d.status        = aids_pkg::ST_OK;
        res_d.element       = mem_rdata;
        res_d.element_index = 6'(ra_q);
        res_d.entry_count   = 7'(count_q);
        res_d.last          = dmp_last;
        if (dmp_last) begin
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ra_q + AW'(1);
          ra_d      = ra_q + AW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    ra_q  <= ra_d;
    wa_q  <= wa_d;
    end_q <= end_d;
    up_q  <= up_d;
    put_q <= put_d;
    val_q <= val_d;
    i_q   <= i_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same entry in one cycle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> busy_o)
    else $error("non-final result while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> !busy_o)
    else $error("final result while still busy");

endmodule

// ===== hdl/aids_ram.sv =====
module aids_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = aids_pkg::DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
